FILE: rtl/core/fabrik_ik_chain_solver_defines.svh
// Assertion macros for the FABRIK chain solver.
`ifndef FABRIK_IK_CHAIN_SOLVER_DEFINES_SVH
`define FABRIK_IK_CHAIN_SOLVER_DEFINES_SVH
`ifndef NO_ASSERTIONS
`define FIK_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);
`define FIK_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);
`else
`define FIK_ASSERT_SAME(lbl, ante, cons, msg)
`define FIK_ASSERT_NEXT(lbl, ante, cons, msg)
`endif
`endif

FILE: rtl/core/fik_pkg.sv
`timescale 1ns / 1ps
package fik_pkg;

  localparam int unsigned MAX_JOINTS   = 16;
  localparam int unsigned SOLVE_ROUNDS = 10;

  localparam int unsigned COORD_W = 32;
  localparam int unsigned IDX_W   = $clog2(MAX_JOINTS);
  localparam int unsigned CNT_W   = $clog2(MAX_JOINTS + 1);
  localparam int unsigned RND_W   = (SOLVE_ROUNDS > 1) ? $clog2(SOLVE_ROUNDS) : 1;
  localparam int unsigned TOT_W   = COORD_W + IDX_W;
  localparam int unsigned MAG_W   = COORD_W + 1;
  localparam int unsigned NUM_W   = 62;
  localparam int unsigned STEPS   = 32;
  localparam int unsigned STEP_W  = $clog2(STEPS);

  typedef logic signed [COORD_W-1:0] coord_t;

  typedef enum logic [4:0] {
    ST_IDLE, ST_SEG_FIRST, ST_SEG_FIRST_LD, ST_SEG_RD, ST_SEG_LD, ST_SEG_WR,
    ST_DIST_SET, ST_DIST_CMP, ST_FAR_RD, ST_FAR_LD, ST_FAR_WR,
    ST_BW_START, ST_BW_RD, ST_BW_LD, ST_BW_WR,
    ST_FW_START, ST_FW_RD, ST_FW_LD, ST_FW_WR, ST_ROUND,
    ST_EMIT_RD, ST_EMIT_OUT,
    ST_MAG_MUL, ST_MAG_ACC, ST_MAG_SQRT, ST_MAG_WAIT,
    ST_PL_CHK, ST_PL_DIV, ST_PL_DWAIT, ST_PL_MUL, ST_PL_RND, ST_PL_SUM
  } fsm_e;

  typedef struct packed {
    logic start;
  } unit_req_t;

  typedef struct packed {
    logic done;
  } unit_rsp_t;

endpackage

FILE: rtl/core/fik_sqrt.sv
`timescale 1ns / 1ps
module fik_sqrt (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  fik_pkg::unit_req_t  req_i,
  input  logic [63:0]         radicand_i,
  output fik_pkg::unit_rsp_t  rsp_o,
  output logic [31:0]         root_o
);

  logic                        active_q, active_d;
  logic                        done_q, done_d;
  logic [fik_pkg::STEP_W-1:0]  cnt_q, cnt_d;
  logic [63:0]                 x_q, x_d;
  logic [33:0]                 rem_q, rem_d;
  logic [31:0]                 root_q, root_d;
  logic [35:0]                 rem_sh, trial, diff;

  assign rem_sh = {rem_q, x_q[63:62]};
  assign trial  = {2'b00, root_q, 2'b01};
  assign diff   = rem_sh - trial;

  always_comb begin
    active_d = active_q;
    done_d   = 1'b0;
    cnt_d    = cnt_q;
    x_d      = x_q;
    rem_d    = rem_q;
    root_d   = root_q;
    if (req_i.start) begin
      active_d = 1'b1;
      cnt_d    = '0;
      x_d      = radicand_i;
      rem_d    = '0;
      root_d   = '0;
    end else if (active_q) begin
      x_d   = {x_q[61:0], 2'b00};
      cnt_d = cnt_q + 1'b1;
      if (rem_sh >= trial) begin
        rem_d  = diff[33:0];
        root_d = {root_q[30:0], 1'b1};
      end else begin
        rem_d  = rem_sh[33:0];
        root_d = {root_q[30:0], 1'b0};
      end
      if (cnt_q == fik_pkg::STEP_W'(fik_pkg::STEPS - 1)) begin
        active_d = 1'b0;
        done_d   = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q <= 1'b0;
      done_q   <= 1'b0;
      cnt_q    <= '0;
    end else begin
      active_q <= active_d;
      done_q   <= done_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    x_q    <= x_d;
    rem_q  <= rem_d;
    root_q <= root_d;
  end

  assign rsp_o.done = done_q;
  assign root_o     = root_q;

endmodule

FILE: rtl/core/fik_div.sv
`timescale 1ns / 1ps
module fik_div (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  fik_pkg::unit_req_t         req_i,
  input  logic [fik_pkg::NUM_W-1:0]  num_i,
  input  logic [fik_pkg::MAG_W-1:0]  den_i,
  output fik_pkg::unit_rsp_t         rsp_o,
  output logic [31:0]                quot_o
);

  logic                        active_q, active_d;
  logic                        done_q, done_d;
  logic [fik_pkg::STEP_W-1:0]  cnt_q, cnt_d;
  logic [31:0]                 n_q, n_d;
  logic [fik_pkg::MAG_W-1:0]   den_q, den_d;
  logic [fik_pkg::MAG_W-1:0]   rem_q, rem_d;
  logic [31:0]                 quot_q, quot_d;
  logic [fik_pkg::MAG_W:0]     rem_sh, diff;

  assign rem_sh = {rem_q, n_q[31]};
  assign diff   = rem_sh - {1'b0, den_q};

  always_comb begin
    active_d = active_q;
    done_d   = 1'b0;
    cnt_d    = cnt_q;
    n_d      = n_q;
    den_d    = den_q;
    rem_d    = rem_q;
    quot_d   = quot_q;
    if (req_i.start) begin
      active_d = 1'b1;
      cnt_d    = '0;
      n_d      = num_i[31:0];
      den_d    = den_i;
      rem_d    = fik_pkg::MAG_W'(num_i[fik_pkg::NUM_W-1:32]);
      quot_d   = '0;
    end else if (active_q) begin
      n_d   = {n_q[30:0], 1'b0};
      cnt_d = cnt_q + 1'b1;
      if (rem_sh >= {1'b0, den_q}) begin
        rem_d  = diff[fik_pkg::MAG_W-1:0];
        quot_d = {quot_q[30:0], 1'b1};
      end else begin
        rem_d  = rem_sh[fik_pkg::MAG_W-1:0];
        quot_d = {quot_q[30:0], 1'b0};
      end
      if (cnt_q == fik_pkg::STEP_W'(fik_pkg::STEPS - 1)) begin
        active_d = 1'b0;
        done_d   = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q <= 1'b0;
      done_q   <= 1'b0;
      cnt_q    <= '0;
    end else begin
      active_q <= active_d;
      done_q   <= done_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    n_q    <= n_d;
    den_q  <= den_d;
    rem_q  <= rem_d;
    quot_q <= quot_d;
  end

  assign rsp_o.done = done_q;
  assign quot_o     = quot_q;

endmodule

FILE: rtl/core/fabrik_ik_chain_solver.sv
`timescale 1ns / 1ps
`include "fabrik_ik_chain_solver_defines.svh"
// FABRIK chain solver, signed Q16.16.
// Command port: a joint word is taken at a clock edge where start is high and busy is
// low; joints come end effector first, chain_end_i marks the root and closes the chain.
// The target of the root word is the one used. Non-root words give no result, and
// busy stays low between them.
// After the root word busy rises and the chain is solved with one shared 32x32
// multiplier, one 32-step square root and one 32-step divider under one sequencer.
// Placing a joint takes a vector length, then a divide, multiply and round step on each
// of the three axes. Within reach the solve runs SOLVE_ROUNDS rounds of a backward and a
// forward pass; out of reach it places each joint once on the line toward the target.
// Results then leave in load order, each shown for one cycle with valid_o high;
// final_joint_o marks the root, out_of_reach_o is the same in every word of a chain.
// The receiver cannot stall the block.
// Reset clears the joint count and the sequencer; the joint stores need no clearing.
module fabrik_ik_chain_solver (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  start,
  output logic                  busy,
  input  logic signed [31:0]    joint_x_i,
  input  logic signed [31:0]    joint_y_i,
  input  logic signed [31:0]    joint_z_i,
  input  logic signed [31:0]    target_x_i,
  input  logic signed [31:0]    target_y_i,
  input  logic signed [31:0]    target_z_i,
  input  logic                  chain_end_i,
  output logic                  valid_o,
  output logic signed [31:0]    solved_x_o,
  output logic signed [31:0]    solved_y_o,
  output logic signed [31:0]    solved_z_o,
  output logic                  out_of_reach_o,
  output logic                  final_joint_o
);

  localparam int unsigned IDX_W = fik_pkg::IDX_W;
  localparam int unsigned CNT_W = fik_pkg::CNT_W;
  localparam int unsigned RND_W = fik_pkg::RND_W;
  localparam int unsigned TOT_W = fik_pkg::TOT_W;
  localparam int unsigned MAG_W = fik_pkg::MAG_W;

  fik_pkg::fsm_e state_q, state_d, ret_q, ret_d;
  logic place_q, place_d;
  logic far_q, far_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic [IDX_W-1:0] i_q, i_d;
  logic [RND_W-1:0] r_q, r_d;
  logic [1:0] k_q, k_d;

  fik_pkg::coord_t va_q [3];
  fik_pkg::coord_t va_d [3];
  fik_pkg::coord_t vb_q [3];
  fik_pkg::coord_t vb_d [3];
  fik_pkg::coord_t res_q [3];
  fik_pkg::coord_t res_d [3];
  fik_pkg::coord_t root_q [3];
  fik_pkg::coord_t root_d [3];
  fik_pkg::coord_t tgt_q [3];
  fik_pkg::coord_t tgt_d [3];

  logic [31:0] len_q, len_d;
  logic [63:0] acc_q, acc_d, prod_q, prod_d;
  logic [MAG_W-1:0] m_q, m_d;
  logic [TOT_W-1:0] total_q, total_d;
  logic [33:0] o_q, o_d;

  logic valid_q, valid_d, oor_q, oor_d, fin_q, fin_d;
  fik_pkg::coord_t sx_q, sx_d, sy_q, sy_d, sz_q, sz_d;

  logic [95:0] pos_mem [fik_pkg::MAX_JOINTS];
  logic [31:0] seg_mem [fik_pkg::MAX_JOINTS];
  logic pos_we, seg_we;
  logic [IDX_W-1:0] pos_waddr, pos_raddr, seg_raddr;
  logic [95:0] pos_wdata, pos_rd_q;
  logic [31:0] seg_rd_q;

  fik_pkg::unit_req_t sq_req, dv_req;
  fik_pkg::unit_rsp_t sq_rsp, dv_rsp;
  logic [31:0] sq_root, dv_quot;

  logic [32:0] diff [3];
  logic [32:0] ndiff [3];
  logic [31:0] absd [3];
  logic [31:0] bk [3];
  logic sh;
  logic [31:0] bsel, absk, mul_a, mul_b, seg_len;
  logic negk;
  fik_pkg::coord_t vbk, sat_val;
  logic [63:0] rnd;
  logic [35:0] ox, offs, sum;
  logic [MAG_W-1:0] m_new;
  logic far_cmp, accept, single, i_is_last, i_next_last, i_is_zero, k_last, full;
  logic [CNT_W-1:0] last;
  logic [IDX_W-1:0] last_idx, wr_idx;

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      diff[k]  = {va_q[k][31], va_q[k]} - {vb_q[k][31], vb_q[k]};
      ndiff[k] = 33'd0 - diff[k];
      absd[k]  = diff[k][32] ? ndiff[k][31:0] : diff[k][31:0];
    end
    sh = absd[0][31] | absd[1][31] | absd[2][31];
    for (int k = 0; k < 3; k++) begin
      bk[k] = sh ? {1'b0, absd[k][31:1]} : absd[k];
    end
  end

  assign bsel   = bk[k_q];
  assign absk   = absd[k_q];
  assign negk   = diff[k_q][32];
  assign vbk    = vb_q[k_q];
  assign mul_a  = (state_q == fik_pkg::ST_PL_MUL) ? dv_quot : bsel;
  assign mul_b  = (state_q == fik_pkg::ST_PL_MUL) ? len_q : bsel;
  assign prod_d = mul_a * mul_b;
  assign rnd    = prod_q + 64'(1 << 29);
  assign ox     = {2'b00, o_q};
  assign offs   = negk ? (36'd0 - ox) : ox;
  assign sum    = {{4{vbk[31]}}, vbk} + offs;
  assign m_new  = sh ? {sq_root, 1'b0} : {1'b0, sq_root};
  assign seg_len = m_q[MAG_W-1] ? 32'hFFFF_FFFF : m_q[31:0];
  assign far_cmp = TOT_W'(m_q) > total_q;

  always_comb begin
    if (sum[35:31] == 5'b00000 || sum[35:31] == 5'b11111) begin
      sat_val = sum[31:0];
    end else if (sum[35]) begin
      sat_val = 32'sh8000_0000;
    end else begin
      sat_val = 32'sh7FFF_FFFF;
    end
  end

  assign accept      = start && !busy;
  assign last        = cnt_q - 1'b1;
  assign last_idx    = last[IDX_W-1:0];
  assign single      = cnt_q == CNT_W'(1);
  assign i_is_last   = CNT_W'(i_q) == last;
  assign i_next_last = (CNT_W'(i_q) + 1'b1) == last;
  assign i_is_zero   = i_q == '0;
  assign k_last      = k_q == 2'd2;
  assign full        = cnt_q >= CNT_W'(fik_pkg::MAX_JOINTS);
  assign wr_idx      = full ? IDX_W'(fik_pkg::MAX_JOINTS - 1) : cnt_q[IDX_W-1:0];
  assign busy        = state_q != fik_pkg::ST_IDLE;

  assign sq_req.start = state_q == fik_pkg::ST_MAG_SQRT;
  assign dv_req.start = state_q == fik_pkg::ST_PL_DIV;

  fik_sqrt u_sqrt (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .req_i      (sq_req),
    .radicand_i (acc_q),
    .rsp_o      (sq_rsp),
    .root_o     (sq_root)
  );

  fik_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (dv_req),
    .num_i  ({absk, 30'd0}),
    .den_i  (m_q),
    .rsp_o  (dv_rsp),
    .quot_o (dv_quot)
  );

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      fik_pkg::ST_IDLE:         if (accept && chain_end_i) state_d = fik_pkg::ST_SEG_FIRST;
      fik_pkg::ST_SEG_FIRST:    state_d = fik_pkg::ST_SEG_FIRST_LD;
      fik_pkg::ST_SEG_FIRST_LD: state_d = single ? fik_pkg::ST_DIST_SET : fik_pkg::ST_SEG_RD;
      fik_pkg::ST_SEG_RD:       state_d = fik_pkg::ST_SEG_LD;
      fik_pkg::ST_SEG_LD:       state_d = fik_pkg::ST_MAG_MUL;
      fik_pkg::ST_SEG_WR:       state_d = i_next_last ? fik_pkg::ST_DIST_SET
                                                      : fik_pkg::ST_SEG_RD;
      fik_pkg::ST_DIST_SET:     state_d = fik_pkg::ST_MAG_MUL;
      fik_pkg::ST_DIST_CMP: begin
        if (!far_cmp) state_d = fik_pkg::ST_BW_START;
        else if (single) state_d = fik_pkg::ST_EMIT_RD;
        else state_d = fik_pkg::ST_FAR_RD;
      end
      fik_pkg::ST_FAR_RD:       state_d = fik_pkg::ST_FAR_LD;
      fik_pkg::ST_FAR_LD:       state_d = fik_pkg::ST_MAG_MUL;
      fik_pkg::ST_FAR_WR:       state_d = i_is_zero ? fik_pkg::ST_EMIT_RD : fik_pkg::ST_FAR_RD;
      fik_pkg::ST_BW_START:     state_d = single ? fik_pkg::ST_FW_START : fik_pkg::ST_BW_RD;
      fik_pkg::ST_BW_RD:        state_d = fik_pkg::ST_BW_LD;
      fik_pkg::ST_BW_LD:        state_d = fik_pkg::ST_MAG_MUL;
      fik_pkg::ST_BW_WR:        state_d = i_is_last ? fik_pkg::ST_FW_START : fik_pkg::ST_BW_RD;
      fik_pkg::ST_FW_START:     state_d = single ? fik_pkg::ST_ROUND : fik_pkg::ST_FW_RD;
      fik_pkg::ST_FW_RD:        state_d = fik_pkg::ST_FW_LD;
      fik_pkg::ST_FW_LD:        state_d = fik_pkg::ST_MAG_MUL;
      fik_pkg::ST_FW_WR:        state_d = i_is_zero ? fik_pkg::ST_ROUND : fik_pkg::ST_FW_RD;
      fik_pkg::ST_ROUND:
        state_d = (r_q == RND_W'(fik_pkg::SOLVE_ROUNDS - 1)) ? fik_pkg::ST_EMIT_RD
                                                             : fik_pkg::ST_BW_START;
      fik_pkg::ST_EMIT_RD:      state_d = fik_pkg::ST_EMIT_OUT;
      fik_pkg::ST_EMIT_OUT:     state_d = i_is_last ? fik_pkg::ST_IDLE : fik_pkg::ST_EMIT_RD;
      fik_pkg::ST_MAG_MUL:      state_d = fik_pkg::ST_MAG_ACC;
      fik_pkg::ST_MAG_ACC:      state_d = k_last ? fik_pkg::ST_MAG_SQRT : fik_pkg::ST_MAG_MUL;
      fik_pkg::ST_MAG_SQRT:     state_d = fik_pkg::ST_MAG_WAIT;
      fik_pkg::ST_MAG_WAIT: begin
        if (sq_rsp.done) state_d = place_q ? fik_pkg::ST_PL_CHK : ret_q;
      end
      fik_pkg::ST_PL_CHK: begin
        if (m_q != '0) state_d = fik_pkg::ST_PL_DIV;
        else if (k_last) state_d = ret_q;
      end
      fik_pkg::ST_PL_DIV:       state_d = fik_pkg::ST_PL_DWAIT;
      fik_pkg::ST_PL_DWAIT:     if (dv_rsp.done) state_d = fik_pkg::ST_PL_MUL;
      fik_pkg::ST_PL_MUL:       state_d = fik_pkg::ST_PL_RND;
      fik_pkg::ST_PL_RND:       state_d = fik_pkg::ST_PL_SUM;
      fik_pkg::ST_PL_SUM:       state_d = k_last ? ret_q : fik_pkg::ST_PL_CHK;
      default:                  state_d = fik_pkg::ST_IDLE;
    endcase
  end

  // datapath and memory controls
  always_comb begin
    ret_d   = ret_q;
    place_d = place_q;
    far_d   = far_q;
    cnt_d   = cnt_q;
    i_d     = i_q;
    r_d     = r_q;
    k_d     = k_q;
    va_d    = va_q;
    vb_d    = vb_q;
    res_d   = res_q;
    root_d  = root_q;
    tgt_d   = tgt_q;
    len_d   = len_q;
    acc_d   = acc_q;
    m_d     = m_q;
    total_d = total_q;
    o_d     = rnd[63:30];
    valid_d = 1'b0;
    oor_d   = oor_q;
    fin_d   = fin_q;
    sx_d    = sx_q;
    sy_d    = sy_q;
    sz_d    = sz_q;
    pos_we    = 1'b0;
    pos_waddr = i_q;
    pos_wdata = {res_q[2], res_q[1], res_q[0]};
    pos_raddr = i_q;
    seg_we    = 1'b0;
    seg_raddr = i_q;
    unique case (state_q)
      fik_pkg::ST_IDLE: begin
        if (accept) begin
          pos_we    = 1'b1;
          pos_waddr = wr_idx;
          pos_wdata = {joint_z_i, joint_y_i, joint_x_i};
          tgt_d[0]  = target_x_i;
          tgt_d[1]  = target_y_i;
          tgt_d[2]  = target_z_i;
          if (!full) cnt_d = cnt_q + 1'b1;
          total_d = '0;
          i_d     = '0;
        end
      end
      fik_pkg::ST_SEG_FIRST: pos_raddr = '0;
      fik_pkg::ST_SEG_FIRST_LD: begin
        va_d[0] = pos_rd_q[31:0];
        va_d[1] = pos_rd_q[63:32];
        va_d[2] = pos_rd_q[95:64];
      end
      fik_pkg::ST_SEG_RD: pos_raddr = i_q + 1'b1;
      fik_pkg::ST_SEG_LD: begin
        vb_d[0] = pos_rd_q[31:0];
        vb_d[1] = pos_rd_q[63:32];
        vb_d[2] = pos_rd_q[95:64];
        acc_d   = '0;
        k_d     = '0;
        place_d = 1'b0;
        ret_d   = fik_pkg::ST_SEG_WR;
      end
      fik_pkg::ST_SEG_WR: begin
        seg_we  = 1'b1;
        total_d = total_q + TOT_W'(seg_len);
        va_d    = vb_q;
        if (!i_next_last) i_d = i_q + 1'b1;
      end
      fik_pkg::ST_DIST_SET: begin
        root_d  = va_q;
        vb_d    = va_q;
        va_d    = tgt_q;
        acc_d   = '0;
        k_d     = '0;
        place_d = 1'b0;
        ret_d   = fik_pkg::ST_DIST_CMP;
      end
      fik_pkg::ST_DIST_CMP: begin
        far_d = far_cmp;
        r_d   = '0;
        i_d   = (far_cmp && !single) ? (last_idx - 1'b1) : '0;
      end
      fik_pkg::ST_FAR_LD: begin
        len_d   = seg_rd_q;
        va_d    = tgt_q;
        acc_d   = '0;
        k_d     = '0;
        place_d = 1'b1;
        ret_d   = fik_pkg::ST_FAR_WR;
      end
      fik_pkg::ST_FAR_WR: begin
        pos_we = 1'b1;
        vb_d   = res_q;
        if (!i_is_zero) i_d = i_q - 1'b1;
      end
      fik_pkg::ST_BW_START: begin
        pos_we    = 1'b1;
        pos_waddr = '0;
        pos_wdata = {tgt_q[2], tgt_q[1], tgt_q[0]};
        vb_d      = tgt_q;
        i_d       = IDX_W'(1);
      end
      fik_pkg::ST_BW_RD: seg_raddr = i_q - 1'b1;
      fik_pkg::ST_BW_LD, fik_pkg::ST_FW_LD: begin
        va_d[0] = pos_rd_q[31:0];
        va_d[1] = pos_rd_q[63:32];
        va_d[2] = pos_rd_q[95:64];
        len_d   = seg_rd_q;
        acc_d   = '0;
        k_d     = '0;
        place_d = 1'b1;
        ret_d   = (state_q == fik_pkg::ST_BW_LD) ? fik_pkg::ST_BW_WR : fik_pkg::ST_FW_WR;
      end
      fik_pkg::ST_BW_WR: begin
        pos_we = 1'b1;
        vb_d   = res_q;
        if (!i_is_last) i_d = i_q + 1'b1;
      end
      fik_pkg::ST_FW_START: begin
        pos_we    = 1'b1;
        pos_waddr = last_idx;
        pos_wdata = {root_q[2], root_q[1], root_q[0]};
        vb_d      = root_q;
        i_d       = last_idx - 1'b1;
      end
      fik_pkg::ST_FW_WR: begin
        pos_we = 1'b1;
        vb_d   = res_q;
        if (!i_is_zero) i_d = i_q - 1'b1;
      end
      fik_pkg::ST_ROUND: begin
        r_d = r_q + 1'b1;
        i_d = '0;
      end
      fik_pkg::ST_EMIT_OUT: begin
        valid_d = 1'b1;
        sx_d    = pos_rd_q[31:0];
        sy_d    = pos_rd_q[63:32];
        sz_d    = pos_rd_q[95:64];
        oor_d   = far_q;
        fin_d   = i_is_last;
        if (i_is_last) cnt_d = '0;
        else i_d = i_q + 1'b1;
      end
      fik_pkg::ST_MAG_ACC: begin
        acc_d = acc_q + prod_q;
        if (!k_last) k_d = k_q + 1'b1;
      end
      fik_pkg::ST_MAG_WAIT: begin
        if (sq_rsp.done) begin
          m_d = m_new;
          k_d = '0;
        end
      end
      fik_pkg::ST_PL_CHK: begin
        if (m_q == '0) begin
          res_d[k_q] = vbk;
          if (!k_last) k_d = k_q + 1'b1;
        end
      end
      fik_pkg::ST_PL_SUM: begin
        res_d[k_q] = sat_val;
        if (!k_last) k_d = k_q + 1'b1;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= fik_pkg::ST_IDLE;
      ret_q   <= fik_pkg::ST_IDLE;
      place_q <= 1'b0;
      cnt_q   <= '0;
      i_q     <= '0;
      r_q     <= '0;
      k_q     <= '0;
      valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      ret_q   <= ret_d;
      place_q <= place_d;
      cnt_q   <= cnt_d;
      i_q     <= i_d;
      r_q     <= r_d;
      k_q     <= k_d;
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    far_q   <= far_d;
    va_q    <= va_d;
    vb_q    <= vb_d;
    res_q   <= res_d;
    root_q  <= root_d;
    tgt_q   <= tgt_d;
    len_q   <= len_d;
    acc_q   <= acc_d;
    prod_q  <= prod_d;
    m_q     <= m_d;
    total_q <= total_d;
    o_q     <= o_d;
    oor_q   <= oor_d;
    fin_q   <= fin_d;
    sx_q    <= sx_d;
    sy_q    <= sy_d;
    sz_q    <= sz_d;
  end

  always_ff @(posedge clk_i) begin
    if (pos_we) pos_mem[pos_waddr] <= pos_wdata;
    pos_rd_q <= pos_mem[pos_raddr];
  end

  always_ff @(posedge clk_i) begin
    if (seg_we) seg_mem[i_q] <= seg_len;
    seg_rd_q <= seg_mem[seg_raddr];
  end

  assign valid_o        = valid_q;
  assign solved_x_o     = sx_q;
  assign solved_y_o     = sy_q;
  assign solved_z_o     = sz_q;
  assign out_of_reach_o = oor_q;
  assign final_joint_o  = fin_q;

  `FIK_ASSERT_NEXT(a_accept_quiet, start && !busy, !valid_o, "word shown after accept")
  `FIK_ASSERT_NEXT(a_strobe_single, valid_o, !valid_o, "result strobe held two cycles")
  `FIK_ASSERT_NEXT(a_root_busy, start && !busy && chain_end_i, busy, "no solve after root")
  `FIK_ASSERT_SAME(a_strobe_src, valid_o, $past(busy), "result word while idle")

endmodule
